[src/ffba_pkg.sv]
// Package for the first-fit boundary allocator.
// Holds request codes and header entry type; no dependencies.
package ffba_pkg;

  typedef enum logic [1:0] {
    REQ_ALLOC = 2'd0,
    REQ_FREE  = 2'd1,
    REQ_INFO  = 2'd2,
    REQ_NONE  = 2'd3
  } req_e;

  // Block header record stored at each block start offset
  typedef struct packed {
    logic        start;
    logic        free;
    logic [16:0] size;
    logic [15:0] req;
    logic [15:0] prev;
  } hdr_t;

endpackage

[src/first_fit_boundary_allocator_top.sv]
// Top level of the first-fit boundary allocator.
// Depends on ffba_pkg, ffba_ctrl and ffba_hdr_mem.
//
//  channel | signals                                  | direction
//  cfg     | cfg_we_i, cfg_wdata_i                    | in, no wait
//  in      | in_valid_i/in_ready_o, req_type_i, ...   | in
//  out     | out_valid_o/out_ready_i, ok_o, ...       | out
//
// Allocate and info walk the blocks one header read at a time; a split adds
// a remainder write and, if a follower exists, its relink. Free checks the
// header and the next and previous blocks, then writes back and relinks; an
// offset that names no allocated block ends after the header check, and an
// offset outside the arena or an unknown request goes straight to the result.
// After reset or an arena_size write a clearing pass over all ARENA_BYTES
// entries and an init step run before any beat is accepted. The result is
// held in an output register until taken; input waits until idle again.
module first_fit_boundary_allocator_top import ffba_pkg::*; #(
  parameter int unsigned ARENA_BYTES  = 4096,
  parameter int unsigned HEADER_BYTES = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [12:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  req_type_i,
  input  logic [11:0] amount_or_offset_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        ok_o,
  output logic [11:0] payload_off_o,
  output logic [8:0]  alloc_count_o,
  output logic [12:0] used_bytes_o,
  output logic [11:0] largest_free_o
);

  localparam int unsigned AW = $clog2(ARENA_BYTES);

  logic          we;
  logic [AW-1:0] waddr, raddr;
  hdr_t          wdata, rdata;

  ffba_ctrl #(
    .ArenaBytes(ARENA_BYTES), .HeaderBytes(HEADER_BYTES), .AW(AW)
  ) u_ctrl (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i, .in_ready_o,
    .req_type_i, .amount_or_offset_i, .out_valid_o, .out_ready_i, .ok_o,
    .payload_off_o, .alloc_count_o, .used_bytes_o, .largest_free_o,
    .mem_we_o(we), .mem_waddr_o(waddr), .mem_wdata_o(wdata),
    .mem_raddr_o(raddr), .mem_rdata_i(rdata)
  );

  ffba_hdr_mem #(.Depth(ARENA_BYTES), .AW(AW)) u_mem (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

endmodule

[src/ffba_hdr_mem.sv]
// Header memory: one write port and one read port, registered read data.
// Depends on ffba_pkg.
module ffba_hdr_mem import ffba_pkg::*; #(
  parameter int unsigned Depth = 4096,
  parameter int unsigned AW    = 12
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  hdr_t          wdata_i,
  input  logic [AW-1:0] raddr_i,
  output hdr_t          rdata_o
);

  hdr_t mem_q [Depth];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[src/ffba_ctrl.sv]
// Sequencer for allocate, free, info, clear and arena init.
// Depends on ffba_pkg; drives the header memory ports.
module ffba_ctrl import ffba_pkg::*; #(
  parameter int unsigned ArenaBytes  = 4096,
  parameter int unsigned HeaderBytes = 10,
  parameter int unsigned AW          = 12
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [12:0]   cfg_wdata_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [1:0]    req_type_i,
  input  logic [11:0]   amount_or_offset_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic          ok_o,
  output logic [11:0]   payload_off_o,
  output logic [8:0]    alloc_count_o,
  output logic [12:0]   used_bytes_o,
  output logic [11:0]   largest_free_o,
  output logic          mem_we_o,
  output logic [AW-1:0] mem_waddr_o,
  output hdr_t          mem_wdata_o,
  output logic [AW-1:0] mem_raddr_o,
  input  hdr_t          mem_rdata_i
);

  localparam logic [16:0] Hdr  = 17'(HeaderBytes);
  localparam logic [16:0] MaxA = 17'(ArenaBytes);

  typedef enum logic [3:0] {
    S_CLEAR, S_INIT, S_IDLE,
    S_AREAD, S_ACHK, S_ASPL,
    S_FREAD, S_FCHK, S_FNCHK, S_FPCHK, S_FWB,
    S_LINK,
    S_IREAD, S_ICHK, S_OUT
  } state_e;

  state_e      state_q;
  logic [16:0] arena_q;
  logic [16:0] cur_q;     // current block offset
  logic [16:0] aux_q;     // split or follower offset
  logic [16:0] want_q;
  logic [16:0] size_q;    // size of the split-off remainder
  hdr_t        hb_q;      // header of the block being freed
  logic [16:0] clr_q;
  logic [8:0]  cnt_q;
  logic [12:0] bytes_q;
  logic [16:0] maxf_q;
  logic        ok_q;
  logic [11:0] uoff_q;
  logic        nxt_ok_q;  // block after the freed one lies inside the arena
  logic        cfg_pend_q;

  logic [16:0] pay, nxt, csat, fol, aux_end, foff;
  logic        fit, split, fbad;
  hdr_t        init_hdr, take_hdr, split_hdr, link_hdr, rel_hdr, freed_hdr, absorb_hdr;

  assign pay     = mem_rdata_i.size - Hdr;
  assign nxt     = cur_q + mem_rdata_i.size;
  assign fol     = cur_q + hb_q.size;
  assign aux_end = aux_q + size_q;
  assign fit     = mem_rdata_i.free && (pay >= want_q);
  assign split   = pay > (want_q + Hdr);
  assign foff    = 17'(amount_or_offset_i) - Hdr;
  assign fbad    = (17'(amount_or_offset_i) < Hdr) || (foff >= arena_q);
  assign csat    = (17'(cfg_wdata_i) < Hdr) ? Hdr :
                   ((17'(cfg_wdata_i) > MaxA) ? MaxA : 17'(cfg_wdata_i));

  // Header images written back to memory
  always_comb begin
    init_hdr       = '0;
    init_hdr.start = 1'b1;
    init_hdr.free  = 1'b1;
    init_hdr.size  = arena_q;
    // block taken by an allocation, trimmed on a split
    take_hdr       = mem_rdata_i;
    take_hdr.free  = 1'b0;
    take_hdr.req   = want_q[15:0];
    if (split) take_hdr.size = Hdr + want_q;
    // free remainder after a split
    split_hdr       = '0;
    split_hdr.start = 1'b1;
    split_hdr.free  = 1'b1;
    split_hdr.size  = size_q;
    split_hdr.prev  = cur_q[15:0];
    // follower pointed back at the current block
    link_hdr      = mem_rdata_i;
    link_hdr.prev = cur_q[15:0];
    // released block
    rel_hdr      = mem_rdata_i;
    rel_hdr.free = 1'b1;
    rel_hdr.req  = '0;
    // released block grown over a free next block
    freed_hdr = hb_q;
    if (nxt_ok_q && mem_rdata_i.free) freed_hdr.size = hb_q.size + mem_rdata_i.size;
    // free previous block absorbing the released one
    absorb_hdr      = mem_rdata_i;
    absorb_hdr.size = mem_rdata_i.size + hb_q.size;
  end

  // Memory port drive
  always_comb begin
    mem_we_o    = 1'b0;
    mem_waddr_o = cur_q[AW-1:0];
    mem_wdata_o = hb_q;
    mem_raddr_o = cur_q[AW-1:0];
    unique case (state_q)
      S_CLEAR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = clr_q[AW-1:0];
        mem_wdata_o = '0;
      end
      S_INIT: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = '0;
        mem_wdata_o = init_hdr;
      end
      S_ACHK: begin
        mem_we_o    = fit;
        mem_wdata_o = take_hdr;
      end
      S_ASPL: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = aux_q[AW-1:0];
        mem_wdata_o = split_hdr;
        mem_raddr_o = aux_end[AW-1:0];
      end
      S_FCHK:  mem_raddr_o = nxt[AW-1:0];
      S_FNCHK: mem_raddr_o = hb_q.prev[AW-1:0];
      S_FPCHK: begin
        // absorbed header no longer marks a block
        mem_we_o    = mem_rdata_i.free;
        mem_wdata_o = '0;
      end
      S_FWB: begin
        mem_we_o    = 1'b1;
        mem_raddr_o = fol[AW-1:0];
      end
      S_LINK: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = aux_q[AW-1:0];
        mem_wdata_o = link_hdr;
      end
      default: ;
    endcase
  end

  assign in_ready_o     = (state_q == S_IDLE) && !cfg_we_i && !cfg_pend_q;
  assign out_valid_o    = (state_q == S_OUT);
  assign ok_o           = ok_q;
  assign payload_off_o  = uoff_q;
  assign alloc_count_o  = cnt_q;
  assign used_bytes_o   = bytes_q;
  assign largest_free_o = maxf_q[11:0];

  // Sequencer: one header read per step
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      arena_q    <= MaxA;
      clr_q      <= '0;
      cur_q      <= '0;
      aux_q      <= '0;
      want_q     <= '0;
      size_q     <= '0;
      hb_q       <= '0;
      cnt_q      <= '0;
      bytes_q    <= '0;
      maxf_q     <= '0;
      ok_q       <= 1'b0;
      uoff_q     <= '0;
      nxt_ok_q   <= 1'b0;
      cfg_pend_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        arena_q    <= csat;
        cfg_pend_q <= 1'b1;
      end
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 17'd1;
          if (clr_q == MaxA - 17'd1) state_q <= S_INIT;
        end
        S_INIT: begin
          if (!cfg_we_i) begin
            cfg_pend_q <= 1'b0;
            state_q    <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (cfg_we_i || cfg_pend_q) begin
            clr_q   <= '0;
            state_q <= S_CLEAR;
          end else if (in_valid_i) begin
            cur_q   <= (req_e'(req_type_i) == REQ_FREE) ? foff : '0;
            want_q  <= 17'(amount_or_offset_i);
            ok_q    <= (req_e'(req_type_i) == REQ_FREE) || (req_e'(req_type_i) == REQ_INFO);
            uoff_q  <= '0;
            cnt_q   <= '0;
            bytes_q <= '0;
            maxf_q  <= '0;
            unique case (req_e'(req_type_i))
              REQ_ALLOC: state_q <= S_AREAD;
              REQ_FREE:  state_q <= fbad ? S_OUT : S_FREAD;
              REQ_INFO:  state_q <= S_IREAD;
              default:   state_q <= S_OUT;
            endcase
          end
        end
        // Allocate walk, first fit
        S_AREAD: state_q <= S_ACHK;
        S_ACHK: begin
          if (fit) begin
            ok_q   <= 1'b1;
            uoff_q <= 12'(cur_q + Hdr);
            if (split) begin
              aux_q   <= cur_q + Hdr + want_q;
              size_q  <= pay - want_q;
              state_q <= S_ASPL;
            end else begin
              state_q <= S_OUT;
            end
          end else if (nxt >= arena_q) begin
            state_q <= S_OUT;
          end else begin
            cur_q   <= nxt;
            state_q <= S_AREAD;
          end
        end
        // Remainder written, follower read for relink
        S_ASPL: begin
          if (aux_end < arena_q) begin
            cur_q   <= aux_q;
            aux_q   <= aux_end;
            state_q <= S_LINK;
          end else begin
            state_q <= S_OUT;
          end
        end
        // Free
        S_FREAD: state_q <= S_FCHK;
        S_FCHK: begin
          if (!mem_rdata_i.start || mem_rdata_i.free) begin
            state_q <= S_OUT;
          end else begin
            hb_q     <= rel_hdr;
            nxt_ok_q <= (nxt < arena_q);
            state_q  <= S_FNCHK;
          end
        end
        S_FNCHK: begin
          hb_q    <= freed_hdr;
          state_q <= (cur_q != 17'd0) ? S_FPCHK : S_FWB;
        end
        S_FPCHK: begin
          if (mem_rdata_i.free) begin
            cur_q <= 17'(hb_q.prev);
            hb_q  <= absorb_hdr;
          end
          state_q <= S_FWB;
        end
        // Write back freed header, read follower for relink
        S_FWB: begin
          if (fol < arena_q) begin
            aux_q   <= fol;
            state_q <= S_LINK;
          end else begin
            state_q <= S_OUT;
          end
        end
        S_LINK: state_q <= S_OUT;
        // Info walk
        S_IREAD: state_q <= S_ICHK;
        S_ICHK: begin
          if (mem_rdata_i.free) begin
            if (pay > maxf_q) maxf_q <= pay;
          end else begin
            cnt_q   <= cnt_q + 9'd1;
            bytes_q <= bytes_q + 13'(mem_rdata_i.req);
          end
          if (nxt >= arena_q) begin
            state_q <= S_OUT;
          end else begin
            cur_q   <= nxt;
            state_q <= S_IREAD;
          end
        end
        S_OUT: if (out_ready_i) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

[src/ffba_checker.sv]
// Port-level checker for the allocator top level, with its bind.
// Depends on first_fit_boundary_allocator_top ports only.
module ffba_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        ok_o,
  input logic [11:0] payload_off_o
);

  // One item at a time: no new beat while a result waits
  a_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("accept while result pending");

  // A result without ok, such as a failed allocation, gives offset zero
  a_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !ok_o) |-> (payload_off_o == 12'd0)) else $error("offset on fail");

  // Result holds while stalled
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(payload_off_o)))
    else $error("result dropped");

  // An accepted beat closes the input for the next cycle
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o) else $error("back to back accept");

endmodule

bind first_fit_boundary_allocator_top ffba_checker u_chk (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
  .ok_o, .payload_off_o
);

[tb/tb_first_fit_boundary_allocator_top.sv]
// Testbench for the first-fit boundary allocator: directed and random requests,
// predicted by an in-bench arena model and checked beat by beat in a scoreboard.
// Depends on ffba_pkg and first_fit_boundary_allocator_top.
`timescale 1ns / 100ps

module tb_first_fit_boundary_allocator_top;
  import ffba_pkg::*;

  localparam int unsigned ARENA = 4096;
  localparam int unsigned HDR   = 10;

  typedef struct packed {
    logic        ok;
    logic [11:0] payload_off;
    logic [8:0]  alloc_count;
    logic [12:0] used_bytes;
    logic [11:0] largest_free;
  } alloc_rsp_t;

  // Arena model plus queue of pending responses
  class alloc_scoreboard;
    int unsigned arena_len;
    bit          is_start [ARENA];
    bit          is_free  [ARENA];
    int unsigned bsize    [ARENA];
    int unsigned breq     [ARENA];
    int unsigned bprev    [ARENA];
    alloc_rsp_t  pending_rsp[$];
    int unsigned errors;
    int unsigned live_offs[$];

    function void set_arena(int unsigned v);
      if (v < HDR) v = HDR;
      if (v > ARENA) v = ARENA;
      arena_len = v;
      for (int i = 0; i < ARENA; i++) begin
        is_start[i] = 0; is_free[i] = 0; bsize[i] = 0; breq[i] = 0; bprev[i] = 0;
      end
      is_start[0] = 1;
      is_free[0]  = 1;
      bsize[0]    = arena_len;
      live_offs.delete();
    endfunction

    function void relink(int unsigned b);
      int unsigned n;
      n = b + bsize[b];
      if (n < arena_len) bprev[n] = b;
    endfunction

    // Predict the response to one accepted request
    function void note_request(req_e kind, logic [11:0] arg);
      alloc_rsp_t r;
      int unsigned b, pay, n, p;
      r = '0;
      case (kind)
        REQ_ALLOC: begin
          b = 0;
          while (b < arena_len) begin
            pay = bsize[b] - HDR;
            if (is_free[b] && pay >= arg) begin
              if (pay > arg + HDR) begin
                n = b + HDR + arg;
                is_start[n] = 1; is_free[n] = 1; bsize[n] = pay - arg;
                breq[n] = 0; bprev[n] = b;
                relink(n);
                bsize[b] = HDR + arg;
              end
              is_free[b] = 0;
              breq[b] = 32'(arg);
              r.ok = 1;
              r.payload_off = 12'(b + HDR);
              live_offs.push_back(b + HDR);
              break;
            end
            b += bsize[b];
          end
        end
        REQ_FREE: begin
          r.ok = 1;
          if (arg >= HDR) begin
            b = arg - HDR;
            if (b < arena_len && is_start[b] && !is_free[b]) begin
              is_free[b] = 1;
              breq[b] = 0;
              n = b + bsize[b];
              if (n < arena_len && is_free[n]) begin
                bsize[b] += bsize[n];
                is_start[n] = 0;
              end
              if (b != 0 && is_free[bprev[b]]) begin
                p = bprev[b];
                bsize[p] += bsize[b];
                is_start[b] = 0;
                b = p;
              end
              relink(b);
            end
          end
        end
        REQ_INFO: begin
          int unsigned cnt, bytes, maxf;
          cnt = 0; bytes = 0; maxf = 0;
          r.ok = 1;
          b = 0;
          while (b < arena_len) begin
            if (is_free[b]) begin
              if (bsize[b] - HDR > maxf) maxf = bsize[b] - HDR;
            end else begin
              cnt++;
              bytes += breq[b];
            end
            b += bsize[b];
          end
          r.alloc_count = 9'(cnt);
          r.used_bytes = 13'(bytes);
          r.largest_free = 12'(maxf);
        end
        default: r = '0;
      endcase
      pending_rsp.push_back(r);
    endfunction

    function void check_response(alloc_rsp_t got);
      alloc_rsp_t exp;
      if (pending_rsp.size() == 0) begin
        $display("%0t: unexpected response beat %p", $time, got);
        errors++;
        return;
      end
      exp = pending_rsp.pop_front();
      if (got.ok !== exp.ok) begin
        $display("%0t: ok exp %0d got %0d", $time, exp.ok, got.ok); errors++;
      end
      if (got.payload_off !== exp.payload_off) begin
        $display("%0t: payload_off exp %0d got %0d", $time, exp.payload_off,
                 got.payload_off); errors++;
      end
      if (got.alloc_count !== exp.alloc_count) begin
        $display("%0t: alloc_count exp %0d got %0d", $time, exp.alloc_count,
                 got.alloc_count); errors++;
      end
      if (got.used_bytes !== exp.used_bytes) begin
        $display("%0t: used_bytes exp %0d got %0d", $time, exp.used_bytes,
                 got.used_bytes); errors++;
      end
      if (got.largest_free !== exp.largest_free) begin
        $display("%0t: largest_free exp %0d got %0d", $time, exp.largest_free,
                 got.largest_free); errors++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [12:0] cfg_wdata_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  req_type_i;
  logic [11:0] amount_or_offset_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic        ok_o;
  logic [11:0] payload_off_o;
  logic [8:0]  alloc_count_o;
  logic [12:0] used_bytes_o;
  logic [11:0] largest_free_o;

  alloc_scoreboard sb;
  bit idle_off;      // no-idling stretch
  bit hold_rx;       // long receiver hold-off

  first_fit_boundary_allocator_top dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_o, .req_type_i, .amount_or_offset_i,
    .out_valid_o, .out_ready_i, .ok_o, .payload_off_o,
    .alloc_count_o, .used_bytes_o, .largest_free_o
  );

  initial begin
    clk_i = 0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #80ms;
    $display("Simulation FAILED");
    $finish;
  end

  // Receiver: random stalls, plus the long hold-off
  initial begin
    out_ready_i = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i && rst_ni)
        sb.check_response({ok_o, payload_off_o, alloc_count_o, used_bytes_o,
                           largest_free_o});
      out_ready_i <= !hold_rx && (idle_off || $urandom_range(99) >= 28);
    end
  end

  // Send one request beat, with optional leading idle cycles
  task automatic send_req(req_e kind, logic [11:0] arg);
    while (!idle_off && $urandom_range(99) < 28) begin
      in_valid_i <= 0;
      @(posedge clk_i);
    end
    in_valid_i <= 1;
    req_type_i <= kind;
    amount_or_offset_i <= arg;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(kind, arg);
  endtask

  // Wait for all responses, let the block settle, then write arena_size
  task automatic write_arena(logic [12:0] v);
    int unsigned guard;
    in_valid_i <= 0;
    guard = 0;
    while (sb.pending_rsp.size() != 0 && guard < 2000000) begin
      @(posedge clk_i); guard++;
    end
    repeat (40) @(posedge clk_i);
    cfg_we_i <= 1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 0;
    sb.set_arena(v);
  endtask

  // Mostly sensible requests: small allocs, frees of live blocks, queries
  task automatic random_req();
    int unsigned sel, idx;
    logic [11:0] arg;
    sel = $urandom_range(99);
    if (sel < 45) begin
      arg = ($urandom_range(19) == 0) ? 12'($urandom) : 12'($urandom_range(120));
      send_req(REQ_ALLOC, arg);
    end else if (sel < 80 && sb.live_offs.size() != 0) begin
      idx = $urandom_range(sb.live_offs.size() - 1);
      arg = 12'(sb.live_offs[idx]);
      sb.live_offs.delete(idx);
      send_req(REQ_FREE, arg);
    end else if (sel < 88) begin
      send_req(REQ_FREE, 12'($urandom));
    end else if (sel < 97) begin
      send_req(REQ_INFO, 12'($urandom));
    end else begin
      send_req(REQ_NONE, 12'($urandom));
    end
  endtask

  initial begin
    int unsigned guard;
    sb = new();
    sb.set_arena(ARENA);
    rst_ni = 0;
    cfg_we_i = 0;
    cfg_wdata_i = '0;
    in_valid_i = 0;
    req_type_i = REQ_NONE;
    amount_or_offset_i = '0;
    idle_off = 0;
    hold_rx = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1;

    // Directed: field extremes, every request kind, special cases
    send_req(REQ_INFO, 12'hFFF);
    send_req(REQ_ALLOC, 12'd0);
    send_req(REQ_ALLOC, 12'd4095);
    send_req(REQ_ALLOC, 12'd100);
    send_req(REQ_ALLOC, 12'd50);
    send_req(REQ_FREE, 12'd20);
    send_req(REQ_FREE, 12'd20);           // double free
    send_req(REQ_FREE, 12'd5);            // below header
    send_req(REQ_FREE, 12'hFFF);
    send_req(REQ_FREE, 12'd10);           // merges with free next
    send_req(REQ_INFO, 12'd0);
    send_req(REQ_NONE, 12'hFFF);
    send_req(REQ_ALLOC, 12'd4086);        // whole arena payload
    send_req(REQ_INFO, 12'd0);
    write_arena(13'd0);                   // saturates to one header
    send_req(REQ_ALLOC, 12'd0);
    send_req(REQ_ALLOC, 12'd0);
    send_req(REQ_INFO, 12'd0);
    write_arena(13'h1FFF);                // saturates to arena max
    send_req(REQ_ALLOC, 12'd4085);
    send_req(REQ_INFO, 12'd0);
    write_arena(13'd40);
    send_req(REQ_ALLOC, 12'd9);
    send_req(REQ_ALLOC, 12'd1);
    send_req(REQ_INFO, 12'd0);

    // Random phases over several arena sizes
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: write_arena(13'd4096);
        1: write_arena(13'd300);
        2: write_arena(13'd10);
        3: write_arena(13'($urandom_range(64, 4096)));
        4: write_arena(13'd1000);
        default: write_arena(13'd4096);
      endcase
      idle_off = (ph == 4);
      if (ph == 1) begin
        fork
          begin
            hold_rx = 1;
            repeat (400) @(posedge clk_i);
            hold_rx = 0;
          end
        join_none
      end
      for (int i = 0; i < 300; i++) random_req();
    end
    idle_off = 0;
    in_valid_i <= 0;

    guard = 0;
    while (sb.pending_rsp.size() != 0 && guard < 2000000) begin
      @(posedge clk_i); guard++;
    end
    repeat (50) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_rsp.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
